FILE: rtl/mlt_pkg.sv
// Package for the MAC learning table: status codes, actions, widths and
// the control/status structs shared by controller and datapath. No dependencies.
package mlt_pkg;
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int NUM_PORTS_DEF = 16;
  localparam int MAC_W = 48;
  localparam int PORT_W = 4;
  localparam int AGE_W = 8;
  localparam int CNT_W = 7;
  localparam logic [7:0] AGE_RESET = 8'd30;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_LEARN = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_NEW = 3'd2;
  localparam logic [2:0] ST_REFRESH = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;

  typedef struct packed {
    logic load;       // capture the input beat
    logic scan_clr;   // clear scan index and flags
    logic scan_step;  // examine one slot, advance index
    logic commit;     // apply the lookup/learn outcome
    logic respond;    // drive the result strobe
  } mlt_cmd_t;

  typedef struct packed {
    logic scan_last;  // current slot is the last one
    logic found;      // a matching valid slot was seen
  } mlt_sts_t;
endpackage

FILE: rtl/mlt_datapath.sv
// Datapath of the MAC learning table: slot memories, valid bits, scan index,
// match and free-slot tracking, tick processing. Depends on mlt_pkg.
module mlt_datapath #(
  parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mlt_pkg::mlt_cmd_t           cmd,
  output mlt_pkg::mlt_sts_t           sts,
  input  logic [1:0]                  action,
  input  logic [mlt_pkg::MAC_W-1:0]   mac_address,
  input  logic [mlt_pkg::PORT_W-1:0]  port_in,
  input  logic [mlt_pkg::AGE_W-1:0]   age_limit,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [mlt_pkg::PORT_W-1:0]  port_out,
  output logic [mlt_pkg::CNT_W-1:0]   removed_count
);
  import mlt_pkg::*;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [MAC_W-1:0]  mem_mac  [TABLE_ENTRIES];
  logic [PORT_W-1:0] mem_port [TABLE_ENTRIES];
  logic [AGE_W-1:0]  mem_age  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  logic [1:0]        act_r;
  logic [MAC_W-1:0]  mac_r;
  logic [PORT_W-1:0] port_r;
  logic [IDX_W-1:0]  idx;
  logic              found, free_seen;
  logic [IDX_W-1:0]  hit_idx, free_idx;
  logic [PORT_W-1:0] hit_port;
  logic [CNT_W-1:0]  count;

  // Registered read of the slot under the scan index.
  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;
  logic [AGE_W-1:0]  rd_age;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_live;

  assign sts.scan_last = (idx == IDX_LAST);
  assign sts.found = found;

  always_ff @(posedge clk) begin
    rd_mac <= mem_mac[idx];
    rd_port <= mem_port[idx];
    rd_age <= mem_age[idx];
    rd_valid <= valid[idx];
    rd_idx <= idx;
    if (cmd.load) begin
      act_r <= action;
      mac_r <= mac_address;
      port_r <= port_in;
    end
    // Tick updates ages as the read data returns, one slot a cycle.
    if (rd_live && act_r == ACT_TICK && rd_valid && rd_age != '0)
      mem_age[rd_idx] <= rd_age - 1'b1;
    if (cmd.commit) begin
      if (found && (act_r == ACT_LOOKUP || act_r == ACT_LEARN)) begin
        mem_age[hit_idx] <= age_limit;
      end else if (!found && act_r == ACT_LEARN && free_seen) begin
        mem_mac[free_idx] <= mac_r;
        mem_port[free_idx] <= port_r;
        mem_age[free_idx] <= age_limit;
      end
    end
    if (cmd.respond) begin
      port_out <= '0;
      removed_count <= '0;
      unique case (act_r)
        ACT_LOOKUP: begin
          status <= found ? ST_HIT : ST_MISS;
          if (found) port_out <= hit_port;
        end
        ACT_LEARN: status <= found ? ST_REFRESH : (free_seen ? ST_NEW : ST_FULL);
        ACT_TICK: begin
          status <= ST_TICK;
          removed_count <= count;
        end
        default: status <= ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done <= 1'b0;
      rd_live <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      free_seen <= 1'b0;
      count <= '0;
    end else begin
      done <= cmd.respond;
      rd_live <= cmd.scan_step;
      if (cmd.scan_clr) begin
        idx <= '0;
        found <= 1'b0;
        free_seen <= 1'b0;
        count <= '0;
      end else if (cmd.scan_step && idx != IDX_LAST) begin
        idx <= idx + 1'b1;
      end
      if (rd_live) begin
        if (act_r == ACT_TICK) begin
          if (rd_valid && rd_age == '0) begin
            valid[rd_idx] <= 1'b0;
            if (count != COUNT_MAX) count <= count + 1'b1;
          end
        end else begin
          if (rd_valid && rd_mac == mac_r && !found) begin
            found <= 1'b1;
            hit_idx <= rd_idx;
            hit_port <= rd_port;
          end
          if (!rd_valid && !free_seen) begin
            free_seen <= 1'b1;
            free_idx <= rd_idx;
          end
        end
      end
      if (cmd.commit && !found && act_r == ACT_LEARN && free_seen)
        valid[free_idx] <= 1'b1;
    end
  end
endmodule

FILE: rtl/mlt_ctrl.sv
// Controller of the MAC learning table: sequences load, slot scan, commit
// and response. Depends on mlt_pkg.
module mlt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output mlt_pkg::mlt_cmd_t cmd,
  input  mlt_pkg::mlt_sts_t sts
);
  import mlt_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_RESP} state_t;
  state_t state;

  assign busy = (state != S_IDLE);
  assign cmd.load = start && !busy;
  assign cmd.scan_clr = start && !busy;
  assign cmd.scan_step = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT);
  assign cmd.respond = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          // The last read is issued here; its data is checked in the drain cycle.
          if (sts.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_COMMIT;
        S_COMMIT: state <= S_RESP;
        S_RESP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/mac_learning_table_with_aging.sv
// Top level of the MAC learning table with aging: configuration register,
// controller and datapath. Depends on mlt_pkg, mlt_ctrl, mlt_datapath.
//
// Each command (lookup, learn or aging tick) scans every slot through one
// registered read port, one slot a cycle, then drains, commits and responds
// with the one-cycle done strobe, which cannot be held off; busy is high from
// the scan through the response and start is taken only while busy is low.
// The result is held until the next response. age_limit is written through the
// cfg_valid/cfg_ready channel, always ready, and should change only when idle.
module mac_learning_table_with_aging #(
  parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF,
  parameter int NUM_PORTS = mlt_pkg::NUM_PORTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [mlt_pkg::MAC_W-1:0]   mac_address,
  input  logic [mlt_pkg::PORT_W-1:0]  port_in,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [mlt_pkg::PORT_W-1:0]  port_out,
  output logic [mlt_pkg::CNT_W-1:0]   removed_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mlt_pkg::AGE_W-1:0]   cfg_data
);
  import mlt_pkg::*;
  logic [AGE_W-1:0] age_limit;
  mlt_cmd_t cmd;
  mlt_sts_t sts;

  assign cfg_ready = (NUM_PORTS > 0);

  always_ff @(posedge clk) begin
    if (rst) age_limit <= AGE_RESET;
    else if (cfg_valid && cfg_ready) age_limit <= cfg_data;
  end

  mlt_ctrl u_ctrl (.clk, .rst, .start, .busy, .cmd, .sts);

  mlt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst, .cmd, .sts, .action, .mac_address, .port_in, .age_limit,
    .done, .status, .port_out, .removed_count
  );

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> done) else $error("done missing after response");
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("busy did not rise after load");
  a_commit_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> cmd.respond) else $error("response did not follow commit");
endmodule

FILE: verif/mac_learning_table_with_aging_test.sv
// Self-checking testbench for the MAC learning table with aging: drives lookup,
// learn, tick and unused-action commands and checks every result against a predictor.
// Depends on mlt_pkg and mac_learning_table_with_aging.
`timescale 1ns / 1ps

module mac_learning_table_with_aging_test;
  import mlt_pkg::*;

  localparam int ENTRIES = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]       status;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  removed;
  } mlt_result_t;

  class mac_table_scoreboard;
    bit               slot_valid[ENTRIES];
    logic [MAC_W-1:0] slot_mac[ENTRIES];
    logic [PORT_W-1:0] slot_port[ENTRIES];
    logic [AGE_W-1:0] slot_age[ENTRIES];
    logic [AGE_W-1:0] age_limit;
    mlt_result_t      pending[$];
    int               mismatches;

    function void clear_table();
      foreach (slot_valid[i]) slot_valid[i] = 0;
      age_limit = AGE_RESET;
      mismatches = 0;
    endfunction

    function int find_slot(logic [MAC_W-1:0] addr);
      foreach (slot_valid[i])
        if (slot_valid[i] && slot_mac[i] == addr) return i;
      return -1;
    endfunction

    // Updates the table for one accepted command and queues its outcome.
    function void note_command(logic [1:0] act, logic [MAC_W-1:0] addr,
                               logic [PORT_W-1:0] pin);
      mlt_result_t r;
      int s;
      r.status = ST_MISS;
      r.port = '0;
      r.removed = '0;
      if (act == ACT_LOOKUP) begin
        s = find_slot(addr);
        if (s >= 0) begin
          slot_age[s] = age_limit;
          r.status = ST_HIT;
          r.port = slot_port[s];
        end
      end else if (act == ACT_LEARN) begin
        s = find_slot(addr);
        if (s >= 0) begin
          slot_age[s] = age_limit;
          r.status = ST_REFRESH;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
              slot_valid[i] = 1;
              slot_mac[i] = addr;
              slot_port[i] = pin;
              slot_age[i] = age_limit;
              r.status = ST_NEW;
              break;
            end
          end
        end
      end else if (act == ACT_TICK) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            if (slot_age[i] == 0) begin
              slot_valid[i] = 0;
              if (r.removed != COUNT_MAX) r.removed++;
            end else begin
              slot_age[i]--;
            end
          end
        end
        r.status = ST_TICK;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [PORT_W-1:0] pt,
                               logic [CNT_W-1:0] rc);
      mlt_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d port %0d removed %0d", st, pt, rc);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || pt !== e.port || rc !== e.removed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d port %0d removed %0d, got %0d %0d %0d",
                   e.status, e.port, e.removed, st, pt, rc);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [1:0]        action = '0;
  logic [MAC_W-1:0]  mac_address = '0;
  logic [PORT_W-1:0] port_in = '0;
  logic              done;
  logic [2:0]        status;
  logic [PORT_W-1:0] port_out;
  logic [CNT_W-1:0]  removed_count;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [AGE_W-1:0]  cfg_data = '0;

  mac_table_scoreboard table_model = new();
  logic [MAC_W-1:0] known_macs[$];
  int               idle_pct = 21;
  int               quiet_cycles = 0;

  mac_learning_table_with_aging u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .mac_address(mac_address), .port_in(port_in), .done(done), .status(status),
    .port_out(port_out), .removed_count(removed_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) table_model.check_result(status, port_out, removed_count);
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One command beat; start stays high until the block takes it.
  task automatic send_command(logic [1:0] act, logic [MAC_W-1:0] addr,
                              logic [PORT_W-1:0] pin);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    action = act;
    mac_address = addr;
    port_in = pin;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_model.note_command(act, addr, pin);
    @(negedge clk);
    start = 0;
  endtask

  task automatic wait_drained();
    while (table_model.pending.size() != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);
  endtask

  task automatic write_age_limit(logic [AGE_W-1:0] value);
    wait_drained();
    cfg_data = value;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    table_model.age_limit = value;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [MAC_W-1:0] pick_mac();
    if (known_macs.size() != 0 && $urandom_range(99) < 75)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    return MAC_W'({$urandom, $urandom});
  endfunction

  task automatic random_phase(int count, int learn_pct, int tick_pct);
    logic [MAC_W-1:0] addr;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      addr = pick_mac();
      if (roll < tick_pct) begin
        send_command(ACT_TICK, addr, 4'($urandom));
      end else if (roll < tick_pct + learn_pct) begin
        send_command(ACT_LEARN, addr, 4'($urandom));
        if (known_macs.size() < 120) known_macs.push_back(addr);
      end else if (roll < 98) begin
        send_command(ACT_LOOKUP, addr, 4'($urandom));
      end else begin
        send_command(ACT_UNUSED, addr, 4'($urandom));
      end
    end
  endtask

  initial begin
    table_model.clear_table();
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed part: address extremes, refresh keeps port, unused action.
    send_command(ACT_LOOKUP, '0, '0);
    send_command(ACT_LEARN, '0, 4'hF);
    send_command(ACT_LEARN, '1, 4'h0);
    send_command(ACT_LEARN, '0, 4'h5);
    send_command(ACT_LOOKUP, '0, 4'h9);
    send_command(ACT_LOOKUP, '1, 4'h9);
    send_command(ACT_UNUSED, '1, 4'hF);
    send_command(ACT_TICK, 48'h5555_5555_5555, 4'hA);
    // Fill the table, then overflow it.
    for (int i = 0; i < ENTRIES + 2; i++)
      send_command(ACT_LEARN, 48'hAAAA_0000_0000 | 48'(i), 4'(i));
    send_command(ACT_LOOKUP, 48'hAAAA_0000_0000 | 48'(ENTRIES - 3), 4'h0);

    // Age limit of zero: every entry refreshed now goes at the next tick.
    write_age_limit(8'd0);
    send_command(ACT_LEARN, '0, 4'h1);
    send_command(ACT_TICK, '0, 4'h0);
    send_command(ACT_LEARN, 48'h1234_5678_9ABC, 4'h7);
    send_command(ACT_TICK, '0, 4'h0);
    send_command(ACT_TICK, '0, 4'h0);
    send_command(ACT_TICK, '0, 4'h0);

    write_age_limit(8'd2);
    random_phase(500, 40, 15);
    write_age_limit(8'd255);
    idle_pct = 0;
    random_phase(300, 45, 5);
    idle_pct = 21;
    write_age_limit(8'd1);
    random_phase(500, 40, 20);
    write_age_limit(8'($urandom_range(3, 10)));
    random_phase(500, 35, 10);

    wait_drained();
    if (table_model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
